>>> rtl/core/input_event_remapper_with_layers_defines.svh
// Assertion macros for the input event remapper.
// Used by ier_front and ier_back; no other dependencies.
`ifndef INPUT_EVENT_REMAPPER_WITH_LAYERS_DEFINES_SVH
`define INPUT_EVENT_REMAPPER_WITH_LAYERS_DEFINES_SVH
// assert that a implies b on the same edge
`define IER_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define IER_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> rtl/core/ier_pkg.sv
// Package for the input event remapper: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ier_pkg;
  localparam int TableEntriesDef = 16;
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [4:0] EVT_SYN = 5'd0;
  localparam logic [4:0] EVT_KEY = 5'd1;
  localparam logic [4:0] EVT_REL = 5'd2;
  localparam logic [15:0] KEY_LCTRL = 16'd29;
  localparam logic [15:0] KEY_C = 16'd46;
  localparam logic [15:0] KEY_V = 16'd47;
  localparam logic [1:0] MAC_COPY  = 2'd1;
  localparam logic [1:0] MAC_PASTE = 2'd2;
  localparam logic [2:0] CFG_TOGGLE = 3'd0;
  localparam logic [2:0] CFG_HOLD   = 3'd1;
  localparam logic [2:0] CFG_COUNT  = 3'd2;
  localparam logic [2:0] CFG_DELAY  = 3'd3;
  localparam logic [2:0] CFG_PERIOD = 3'd4;

  // job handed from front to back
  typedef enum logic [1:0] {
    JOB_TAP = 2'd0, JOB_COMBO = 2'd1, JOB_PASS = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [4:0]  etype;
    logic [15:0] code;   // tap key, combo key or pass code
    logic [31:0] value;
  } job_t;

  typedef struct packed {
    logic [15:0] code;
    logic        from_wheel;
    logic        from_up;
    logic [9:0]  to_key;
    logic [1:0]  macro;
    logic        layer;
  } slot_t;
endpackage
`default_nettype wire

>>> rtl/core/ier_front.sv
// Front part: accepts items, handles layer/repeat state, writes and searches the table.
// Depends on ier_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ier_front #(
  parameter int TABLE_ENTRIES = ier_pkg::TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [81:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic [10:0] toggle_button,
  input  wire logic [10:0] hold_button,
  input  wire logic [4:0]  entry_count,
  input  wire logic [15:0] first_delay,
  input  wire logic [15:0] repeat_period,
  output logic             job_valid,
  output ier_pkg::job_t    job,
  input  wire logic        job_ready
);
  import ier_pkg::*;
  `include "input_event_remapper_with_layers_defines.svh"
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_CHECK = 4'b0100, S_EMIT = 4'b1000
  } state_t;
  state_t state_r, state_nxt;

  slot_t mem [TABLE_ENTRIES];
  slot_t rd_r;
  logic [CW-1:0] idx_r, idx_nxt, limit;
  logic [4:0]  ty_r;
  logic [15:0] cd_r;
  logic [31:0] vl_r;
  logic layer_r, layer_nxt, rep_on_r, rep_on_nxt;
  logic [9:0]  rep_code_r, rep_code_nxt;
  logic [15:0] rep_tmr_r, rep_tmr_nxt;
  job_t job_r, job_nxt;
  logic jv_r, jv_nxt;

  logic [1:0]  k;
  logic [3:0]  widx;
  assign k = in_tuser;
  assign widx = in_tdata[56:53];
  assign in_tready = (state_r == S_IDLE) && !jv_r;
  assign job_valid = jv_r;
  assign job = job_r;
  assign limit = (32'(entry_count) > TABLE_ENTRIES) ? CW'(TABLE_ENTRIES) : CW'(entry_count);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && k == KIND_WRITE && 32'(widx) < TABLE_ENTRIES) begin
      mem[IW'(widx)] <= '{code: {6'd0, in_tdata[67:58]}, from_wheel: in_tdata[57],
        from_up: in_tdata[68], to_key: in_tdata[78:69], macro: in_tdata[80:79],
        layer: in_tdata[81]};
    end
    rd_r <= mem[idx_r[IW-1:0]];
  end

  logic is_tog, is_hold, key_hit, rel_hit;
  logic [15:0] fire_code;
  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; layer_nxt = layer_r; rep_on_nxt = rep_on_r;
    rep_code_nxt = rep_code_r; rep_tmr_nxt = rep_tmr_r; job_nxt = job_r;
    jv_nxt = jv_r && !job_ready;
    is_tog = 1'b0; is_hold = 1'b0; key_hit = 1'b0; rel_hit = 1'b0;
    fire_code = (rd_r.macro == MAC_PASTE) ? KEY_V : KEY_C;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        if (k == KIND_EVENT) begin
          is_tog = in_tdata[4:0] == EVT_KEY && !toggle_button[10] &&
                   in_tdata[20:5] == {5'd0, toggle_button};
          is_hold = in_tdata[4:0] == EVT_KEY && !hold_button[10] &&
                    in_tdata[20:5] == {5'd0, hold_button};
          if (is_tog) begin
            if (in_tdata[52:21] == 32'd1) begin
              layer_nxt = !layer_r; rep_on_nxt = 1'b0;
            end
          end else if (is_hold) begin
            layer_nxt = in_tdata[52:21] != 32'd0; rep_on_nxt = 1'b0;
          end else begin
            idx_nxt = '0; state_nxt = S_READ;
          end
        end else if (k == KIND_TICK && rep_on_r) begin
          if (rep_tmr_r <= 16'd1) begin
            rep_tmr_nxt = repeat_period;
            job_nxt = '{kind: JOB_TAP, etype: EVT_KEY, code: {6'd0, rep_code_r}, value: '0};
            jv_nxt = 1'b1;
          end else rep_tmr_nxt = rep_tmr_r - 16'd1;
        end
      end
      S_READ: begin
        if (idx_r >= limit) begin
          job_nxt = '{kind: JOB_PASS, etype: ty_r, code: cd_r, value: vl_r};
          state_nxt = S_EMIT;
        end else state_nxt = S_CHECK;
      end
      S_CHECK: begin
        key_hit = rd_r.layer == layer_r && ty_r == EVT_KEY && !rd_r.from_wheel &&
                  cd_r == rd_r.code;
        rel_hit = rd_r.layer == layer_r && ty_r == EVT_REL && rd_r.from_wheel &&
                  cd_r == rd_r.code && vl_r == (rd_r.from_up ? 32'd1 : 32'hFFFFFFFF);
        state_nxt = S_IDLE;
        if (key_hit && vl_r == 32'd1 || rel_hit) begin
          state_nxt = S_EMIT;
          if (rd_r.macro == MAC_COPY || rd_r.macro == MAC_PASTE)
            job_nxt = '{kind: JOB_COMBO, etype: EVT_KEY, code: fire_code, value: '0};
          else begin
            job_nxt = '{kind: JOB_TAP, etype: EVT_KEY, code: {6'd0, rd_r.to_key}, value: '0};
            if (key_hit) begin
              rep_on_nxt = 1'b1; rep_code_nxt = rd_r.to_key; rep_tmr_nxt = first_delay;
            end
          end
        end else if (key_hit) begin
          if (vl_r == 32'd0) rep_on_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = S_READ;
        end
      end
      S_EMIT: begin
        jv_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; layer_r <= 1'b0; rep_on_r <= 1'b0; rep_code_r <= '0;
      rep_tmr_r <= '0; jv_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r <= state_nxt; layer_r <= layer_nxt; rep_on_r <= rep_on_nxt;
      rep_code_r <= rep_code_nxt; rep_tmr_r <= rep_tmr_nxt; jv_r <= jv_nxt; idx_r <= idx_nxt;
    end
    job_r <= job_nxt;
    if (in_tvalid && in_tready) begin
      ty_r <= in_tdata[4:0]; cd_r <= in_tdata[20:5]; vl_r <= in_tdata[52:21];
    end
  end

  `IER_ASSERT_IMP(a_idx_bound, clk, rst_n, state_r == S_CHECK, idx_r < limit)
  `IER_ASSERT_NXT(a_emit_valid, clk, rst_n, state_r == S_EMIT, jv_r)
  `IER_ASSERT_IMP(a_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
endmodule
`default_nettype wire

>>> rtl/core/ier_back.sv
// Back part: expands a job into its event sequence on the output stream.
// Depends on ier_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ier_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  input  ier_pkg::job_t    job,
  output logic             job_ready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tlast
);
  import ier_pkg::*;
  `include "input_event_remapper_with_layers_defines.svh"
  job_t j_r;
  logic act_r;
  logic [2:0] pos_r;
  logic [4:0] t; logic [15:0] c; logic [31:0] v; logic lst;
  always_comb begin
    t = EVT_SYN; c = '0; v = '0; lst = 1'b0;
    case (j_r.kind)
      JOB_PASS: begin t = j_r.etype; c = j_r.code; v = j_r.value; lst = 1'b1; end
      JOB_TAP: begin
        lst = pos_r == 3'd3;
        if (!pos_r[0]) begin t = EVT_KEY; c = j_r.code; v = {31'd0, !pos_r[1]}; end
      end
      default: begin
        lst = pos_r == 3'd5;
        case (pos_r)
          3'd0: begin t = EVT_KEY; c = KEY_LCTRL; v = 32'd1; end
          3'd1: begin t = EVT_KEY; c = j_r.code; v = 32'd1; end
          3'd3: begin t = EVT_KEY; c = j_r.code; end
          3'd4: begin t = EVT_KEY; c = KEY_LCTRL; end
          default: ;
        endcase
      end
    endcase
  end
  assign job_ready = !act_r;
  assign out_tvalid = act_r;
  assign out_tdata = {3'd0, v, c, t};
  assign out_tlast = lst;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; pos_r <= '0;
    end else if (!act_r && job_valid) begin
      act_r <= 1'b1; pos_r <= '0;
    end else if (act_r && out_tready) begin
      pos_r <= pos_r + 3'd1;
      if (lst) act_r <= 1'b0;
    end
    if (!act_r && job_valid) j_r <= job;
  end
  `IER_ASSERT_IMP(a_pos, clk, rst_n, act_r, pos_r <= 3'd5)
  `IER_ASSERT_NXT(a_end, clk, rst_n, act_r && out_tready && lst, !act_r)
  `IER_ASSERT_IMP(a_pass, clk, rst_n, act_r && j_r.kind == JOB_PASS, pos_r == 3'd0)
endmodule
`default_nettype wire

>>> rtl/core/input_event_remapper_with_layers.sv
// Top level of the input event remapper with layers and key repeat.
// Depends on ier_pkg, ier_front and ier_back.
`timescale 1ns / 1ps
`default_nettype none
// Remaps input events through a 16-slot table with two layers and key repeat.
// tuser carries the request kind (event, tick, table write). An event request
// is searched in the front slot by slot (table memory read plus compare),
// then its 1, 4 or 6 output events leave the back one per cycle while
// out_tready is high; the one-job register between them lets the front take
// the next request while the back is still sending.
module input_event_remapper_with_layers #(
  parameter int TABLE_ENTRIES = ier_pkg::TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // event_type, event_code, event_value, entry_index, entry_from_wheel,
  // entry_from_code, entry_from_up, entry_to_key, entry_macro, entry_layer
  input  wire logic [87:0] in_tdata,
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // out_type, out_code, out_value
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import ier_pkg::*;
  logic [10:0] tog_r, hold_r;
  logic [4:0]  cnt_r;
  logic [15:0] dly_r, per_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tog_r <= '1; hold_r <= '1; cnt_r <= '0; dly_r <= 16'd500; per_r <= 16'd33;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOGGLE: tog_r <= cfg_wdata[10:0];
        CFG_HOLD:   hold_r <= cfg_wdata[10:0];
        CFG_COUNT:  cnt_r <= cfg_wdata[4:0];
        CFG_DELAY:  dly_r <= cfg_wdata;
        CFG_PERIOD: per_r <= cfg_wdata;
        default: ;
      endcase
    end
  end
  logic jv, jr; job_t jb;
  ier_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata(in_tdata[81:0]), .in_tuser,
    .toggle_button(tog_r), .hold_button(hold_r), .entry_count(cnt_r),
    .first_delay(dly_r), .repeat_period(per_r),
    .job_valid(jv), .job(jb), .job_ready(jr));
  ier_back u_back (
    .clk, .rst_n, .job_valid(jv), .job(jb), .job_ready(jr),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);
endmodule
`default_nettype wire

>>> tb/sv/tb_input_event_remapper_with_layers.sv
// Testbench for input_event_remapper_with_layers: random and directed requests,
// a request-level predictor of layers, table search, macros and key repeat.
// Depends on ier_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module tb_input_event_remapper_with_layers;
  import ier_pkg::*;

  // one request as it travels on the input stream
  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  typ;
    logic [15:0] code;
    logic [31:0] val;
    logic [3:0]  idx;
    logic        wheel;
    logic [9:0]  fcode;
    logic        up;
    logic [9:0]  tkey;
    logic [1:0]  mac;
    logic        lay;
  } req_t;

  // one emitted event
  typedef struct {
    logic [4:0]  typ;
    logic [15:0] code;
    logic [31:0] val;
    logic        last;
  } evt_t;

  typedef struct {
    logic       wheel;
    logic [9:0] fcode;
    logic       up;
    logic [9:0] tkey;
    logic [1:0] mac;
    logic       lay;
  } map_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  input_event_remapper_with_layers u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state and configuration copy
  map_t        remap_tbl [16];
  logic        cur_layer;
  logic        rpt_on;
  logic [9:0]  rpt_key;
  logic [15:0] rpt_timer;
  int          toggle_code;
  int          hold_code;
  int          slots_searched;
  logic [15:0] first_delay;
  logic [15:0] rpt_period;

  req_t pending_reqs[$];
  req_t cur_req;
  evt_t expected_events[$];

  int  errors;
  int  cycles;
  bit  no_idle;
  bit  hold_arm;
  bit  hold_done;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [87:0] pack_req(req_t r);
    return {6'b0, r.lay, r.mac, r.tkey, r.up, r.fcode, r.wheel, r.idx, r.val, r.code, r.typ};
  endfunction

  function automatic void push_evt(logic [4:0] t, logic [15:0] c, logic [31:0] v, logic l);
    evt_t e;
    e.typ = t; e.code = c; e.val = v; e.last = l;
    expected_events.push_back(e);
  endfunction

  function automatic void key_tap(logic [15:0] key);
    push_evt(EVT_KEY, key, 32'd1, 1'b0);
    push_evt(EVT_SYN, 16'd0, 32'd0, 1'b0);
    push_evt(EVT_KEY, key, 32'd0, 1'b0);
    push_evt(EVT_SYN, 16'd0, 32'd0, 1'b1);
  endfunction

  function automatic void ctrl_chord(logic [15:0] key);
    push_evt(EVT_KEY, KEY_LCTRL, 32'd1, 1'b0);
    push_evt(EVT_KEY, key, 32'd1, 1'b0);
    push_evt(EVT_SYN, 16'd0, 32'd0, 1'b0);
    push_evt(EVT_KEY, key, 32'd0, 1'b0);
    push_evt(EVT_KEY, KEY_LCTRL, 32'd0, 1'b0);
    push_evt(EVT_SYN, 16'd0, 32'd0, 1'b1);
  endfunction

  function automatic void fire_slot(map_t s, bit arm);
    if (s.mac == MAC_COPY) ctrl_chord(KEY_C);
    else if (s.mac == MAC_PASTE) ctrl_chord(KEY_V);
    else begin
      if (arm) begin
        rpt_on = 1'b1;
        rpt_key = s.tkey;
        rpt_timer = first_delay;
      end
      key_tap({6'd0, s.tkey});
    end
  endfunction

  function automatic void remap_event(req_t r);
    int lim;
    lim = (slots_searched < 16) ? slots_searched : 16;
    if (r.typ == EVT_KEY && toggle_code >= 0 && r.code == toggle_code[15:0]) begin
      if (r.val == 32'd1) begin
        cur_layer = ~cur_layer;
        rpt_on = 1'b0;
      end
      return;
    end
    if (r.typ == EVT_KEY && hold_code >= 0 && r.code == hold_code[15:0]) begin
      cur_layer = (r.val != 32'd0);
      rpt_on = 1'b0;
      return;
    end
    for (int i = 0; i < lim; i++) begin
      if (remap_tbl[i].lay != cur_layer) continue;
      if (r.typ == EVT_KEY && !remap_tbl[i].wheel && r.code == {6'd0, remap_tbl[i].fcode}) begin
        if (r.val == 32'd1) fire_slot(remap_tbl[i], 1'b1);
        else if (r.val == 32'd0) rpt_on = 1'b0;
        return;
      end
      if (r.typ == EVT_REL && remap_tbl[i].wheel && r.code == {6'd0, remap_tbl[i].fcode} &&
          r.val == (remap_tbl[i].up ? 32'd1 : 32'hFFFF_FFFF)) begin
        fire_slot(remap_tbl[i], 1'b0);
        return;
      end
    end
    push_evt(r.typ, r.code, r.val, 1'b1);
  endfunction

  // expected events for one accepted request
  function automatic void predict_request(req_t r);
    case (r.kind)
      KIND_EVENT: remap_event(r);
      KIND_TICK: begin
        if (rpt_on) begin
          if (rpt_timer <= 16'd1) begin
            rpt_timer = rpt_period;
            key_tap({6'd0, rpt_key});
          end else rpt_timer = rpt_timer - 16'd1;
        end
      end
      KIND_WRITE: begin
        remap_tbl[r.idx].wheel = r.wheel;
        remap_tbl[r.idx].fcode = r.fcode;
        remap_tbl[r.idx].up = r.up;
        remap_tbl[r.idx].tkey = r.tkey;
        remap_tbl[r.idx].mac = r.mac;
        remap_tbl[r.idx].lay = r.lay;
      end
      default: ;
    endcase
  endfunction

  // driver: next request goes out once the current one is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_request(cur_req);
        void'(pending_reqs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > (in_tvalid && in_tready ? 0 : 0) &&
            (no_idle || $urandom_range(99) >= 17)) begin
          cur_req = pending_reqs[0];
          in_tvalid <= 1'b1;
          in_tdata <= pack_req(pending_reqs[0]);
          in_tuser <= pending_reqs[0].kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken event with the oldest expectation
  always @(posedge clk) begin
    evt_t e;
    cycles++;
    if (cycles > 600000) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected event type=%0d code=%0d value=%0d last=%0b",
                     out_tdata[4:0], out_tdata[20:5], $signed(out_tdata[52:21]), out_tlast);
        end else begin
          e = expected_events.pop_front();
          if (out_tdata[4:0] !== e.typ || out_tdata[20:5] !== e.code ||
              out_tdata[52:21] !== e.val || out_tlast !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b", e.typ, e.code,
                       $signed(e.val), e.last, out_tdata[4:0], out_tdata[20:5],
                       $signed(out_tdata[52:21]), out_tlast);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic add_event(logic [4:0] t, logic [15:0] c, logic [31:0] v);
    req_t r;
    r = '{default: '0};
    r.kind = KIND_EVENT; r.typ = t; r.code = c; r.val = v;
    pending_reqs.push_back(r);
  endtask

  task automatic add_tick();
    req_t r;
    r = '{default: '0};
    r.kind = KIND_TICK;
    pending_reqs.push_back(r);
  endtask

  task automatic add_slot(int i, int wh, int fc, int up, int tk, int mc, int ly);
    req_t r;
    r = '{default: '0};
    r.kind = KIND_WRITE; r.idx = 4'(i); r.wheel = 1'(wh); r.fcode = 10'(fc); r.up = 1'(up);
    r.tkey = 10'(tk); r.mac = 2'(mc); r.lay = 1'(ly);
    pending_reqs.push_back(r);
  endtask

  // wait until every request is taken and every event seen, then let the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_events.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_TOGGLE: toggle_code = $signed(val[10:0]);
      CFG_HOLD: hold_code = $signed(val[10:0]);
      CFG_COUNT: slots_searched = val[4:0];
      CFG_DELAY: first_delay = val;
      CFG_PERIOD: rpt_period = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int tg, int hd, int cnt, int dly, int per);
    write_reg(CFG_TOGGLE, tg[15:0] & 16'h07FF);
    write_reg(CFG_HOLD, hd[15:0] & 16'h07FF);
    write_reg(CFG_COUNT, cnt[15:0]);
    write_reg(CFG_DELAY, dly[15:0]);
    write_reg(CFG_PERIOD, per[15:0]);
  endtask

  // mostly well-formed traffic aimed at the table, plus noise
  task automatic random_traffic(int n);
    req_t r;
    int   dice;
    int   s;
    for (int k = 0; k < n; k++) begin
      dice = $urandom_range(99);
      s = $urandom_range(15);
      if (dice < 30) add_tick();
      else if (dice < 55)
        add_event(EVT_KEY, {6'd0, remap_tbl[s].fcode},
                  $urandom_range(9) < 6 ? 32'd1 : ($urandom_range(3) != 0 ? 32'd0 : $urandom));
      else if (dice < 67)
        add_event(EVT_REL, {6'd0, remap_tbl[s].fcode},
                  $urandom_range(4) == 0 ? $urandom : ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF));
      else if (dice < 75)
        add_event(EVT_KEY, $urandom_range(1) ? toggle_code[15:0] : hold_code[15:0],
                  $urandom_range(2));
      else if (dice < 80)
        add_slot(s, $urandom_range(1), $urandom_range(1023), $urandom_range(1),
                 $urandom_range(1023), $urandom_range(3), $urandom_range(1));
      else begin
        r.kind = 2'($urandom); r.typ = 5'($urandom); r.code = 16'($urandom);
        r.val = $urandom; r.idx = 4'($urandom); r.wheel = 1'($urandom);
        r.fcode = 10'($urandom); r.up = 1'($urandom); r.tkey = 10'($urandom);
        r.mac = 2'($urandom); r.lay = 1'($urandom);
        pending_reqs.push_back(r);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    cur_req = '{default: '0};
    for (int i = 0; i < 16; i++) remap_tbl[i] = '{default: '0};
    cur_layer = 1'b0; rpt_on = 1'b0; rpt_key = '0; rpt_timer = '0;
    toggle_code = -1; hold_code = -1; slots_searched = 0;
    first_delay = 16'd500; rpt_period = 16'd33;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing searched, all events pass; fill every slot
    add_event(EVT_KEY, 16'd272, 32'd1);
    add_event(5'd31, 16'hFFFF, 32'h8000_0000);
    add_event(EVT_SYN, 16'd0, 32'h7FFF_FFFF);
    add_tick();
    add_slot(0, 0, 272, 0, 30, 0, 0);
    add_slot(1, 0, 273, 0, 0, MAC_COPY, 0);
    add_slot(2, 1, 8, 1, 103, 0, 0);
    add_slot(3, 1, 8, 0, 0, MAC_PASTE, 0);
    add_slot(4, 0, 274, 1, 767, 3, 0);
    add_slot(5, 0, 272, 0, 48, 0, 1);
    add_slot(6, 1, 6, 1, 105, MAC_COPY, 1);
    for (int i = 7; i < 16; i++)
      add_slot(i, $urandom_range(1), $urandom_range(767), $urandom_range(1),
               $urandom_range(767), $urandom_range(3), $urandom_range(1));
    drain();

    // directed: taps, macros, wheel, repeat, layers, odd values
    setup(5, 6, 16, 1, 1);
    add_event(EVT_KEY, 16'd272, 32'd1);
    add_tick(); add_tick();
    add_event(EVT_KEY, 16'd272, 32'd0);
    add_tick();
    add_event(EVT_KEY, 16'd272, 32'd2);
    add_event(EVT_KEY, 16'd273, 32'd1);
    add_event(EVT_REL, 16'd8, 32'd1);
    add_event(EVT_REL, 16'd8, 32'hFFFF_FFFF);
    add_event(EVT_REL, 16'd8, 32'd2);
    add_event(EVT_KEY, 16'd274, 32'd1);
    add_event(EVT_KEY, 16'd5, 32'd1);
    add_event(EVT_KEY, 16'd272, 32'd1);
    add_event(EVT_REL, 16'd6, 32'd1);
    add_event(EVT_KEY, 16'd5, 32'd0);
    add_event(EVT_KEY, 16'd5, 32'd1);
    add_event(EVT_KEY, 16'd6, 32'd7);
    add_event(EVT_KEY, 16'd272, 32'd1);
    add_event(EVT_KEY, 16'd6, 32'd0);
    add_tick();
    add_event(EVT_KEY, 16'd6, 32'd1);
    add_event(EVT_KEY, 16'd6, 32'd0);
    drain();

    // toggle and hold on the same code; zero timing; oversize count
    setup(272, 272, 31, 0, 0);
    add_event(EVT_KEY, 16'd272, 32'd1);
    add_event(EVT_KEY, 16'd272, 32'd0);
    add_event(EVT_KEY, 16'd274, 32'd1);
    add_tick(); add_tick();
    drain();

    // random phases over several settings
    setup(5, 6, 16, 3, 2);
    random_traffic(60);
    drain();
    setup(767, 767, 0, 65535, 65535);
    random_traffic(25);
    drain();
    setup(-1, -1, 31, 2, 1);
    no_idle = 1'b1;
    random_traffic(40);
    drain();
    no_idle = 1'b0;
    setup(5, 6, 16, 4, 3);
    hold_arm = 1'b1;
    random_traffic(60);
    drain();
    setup(-1, 6, 12, 1, 65535);
    random_traffic(40);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
